// ===== hdl/npsc_pkg.sv =====
// npsc_pkg: shared types, constants and helpers of the nearest point search core
// used by npsc_cell and nearest_point_search_core; no dependencies
package npsc_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_W    = 16;
	localparam int FIELD_W    = 16;
	localparam int NUM_AXES   = 3;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int DSUM_W     = 2 * COORD_W + 2;
	localparam int OUT_IDX_W  = 10;
	localparam int OUT_DIST_W = 34;
	localparam int DIMS_W     = 2;

	localparam logic [DIMS_W-1:0] DIMS_THREE = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_EMIT
	} state_t;

	typedef logic [NUM_AXES-1:0][COORD_W-1:0] point_t;

	// one word traveling down the cell chain
	typedef struct packed {
		logic              vld;
		logic              last;
		logic [IDX_W-1:0]  idx;
		logic [DSUM_W-1:0] sum;
		point_t            pt;
	} word_t;

	// sign-extend or wrap a 16-bit field to the coordinate width
	function automatic logic [COORD_W-1:0] to_coord(input logic signed [FIELD_W-1:0] f);
		return COORD_W'(f);
	endfunction

endpackage

// ===== hdl/npsc_ram.sv =====
// npsc_ram: generic single-write, single-read memory with registered read data
// no dependencies
module npsc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/npsc_cell.sv =====
// npsc_cell: one axis cell of the distance chain; holds one query coordinate,
// adds the squared axis difference to the passing word; depends on npsc_pkg
module npsc_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_load,
	input  logic [npsc_pkg::COORD_W-1:0] q_coord,
	input  logic                         use_axis,
	input  npsc_pkg::word_t              word_in,
	output npsc_pkg::word_t              word_out
);

	logic [npsc_pkg::COORD_W-1:0]   q_q;
	logic [npsc_pkg::COORD_W-1:0]   p;
	logic signed [npsc_pkg::COORD_W:0] diff;
	logic [npsc_pkg::COORD_W:0]     neg;
	logic [npsc_pkg::COORD_W-1:0]   mag;
	logic [2*npsc_pkg::COORD_W-1:0] sq;
	logic [npsc_pkg::DSUM_W-1:0]    sum_next;
	logic                           vld_q;
	npsc_pkg::word_t                pay_q;

	always_ff @(posedge clk) begin
		if (q_load) begin
			q_q <= q_coord;
		end
	end

	always_comb begin
		p        = word_in.pt[0];
		diff     = signed'({p[npsc_pkg::COORD_W-1], p})
		         - signed'({q_q[npsc_pkg::COORD_W-1], q_q});
		neg      = -diff;
		// |diff| always fits the coordinate width
		mag      = diff[npsc_pkg::COORD_W] ? neg[npsc_pkg::COORD_W-1:0]
		                                   : diff[npsc_pkg::COORD_W-1:0];
		sq       = mag * mag;
		sum_next = word_in.sum + (use_axis ? npsc_pkg::DSUM_W'(sq) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= word_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_q.vld  <= 1'b0;
		pay_q.last <= word_in.last;
		pay_q.idx  <= word_in.idx;
		pay_q.sum  <= sum_next;
		// next cell sees the next axis in slot zero
		pay_q.pt   <= word_in.pt >> npsc_pkg::COORD_W;
	end

	always_comb begin
		word_out     = pay_q;
		word_out.vld = vld_q;
	end

endmodule

// ===== hdl/nearest_point_search_core.sv =====
// nearest_point_search_core: top level of the brute-force nearest point search
// depends on npsc_pkg, npsc_ram and npsc_cell
//
// Keeps up to 1024 signed 16-bit points (x, y, z) in one memory, appended one
// per word after a clear. A query word walks the stored points in load order
// and reports the load-order index of the first point at the smallest squared
// Euclidean distance, plus that distance; dimensions (reset 3) selects three
// axes when 3 and two axes (z ignored) for any other value. An empty store
// reports found=0 with index and distance zero; appends to a full store and
// opcode 3 are taken and dropped. A query over N stored points occupies the
// block while the single memory read port hands one point per cycle to a
// chain of three axis cells and while the chain and the minimum tracker drain.
// The result sits in an output register, so the next word is taken while a
// result waits; a second query cannot hand off its result until the first has
// been taken. The point memory holds no reset and needs no clearing pass.
module nearest_point_search_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// command words
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     opcode,
	input  logic signed [15:0]             coord_x,
	input  logic signed [15:0]             coord_y,
	input  logic signed [15:0]             coord_z,
	// result words
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           found,
	output logic [9:0]                     best_index,
	output logic [33:0]                    best_distance_sq,
	// dimensions register
	input  logic                           cfg_write_en,
	input  logic [npsc_pkg::DIMS_W-1:0]    cfg_write_data
);

	// ---------------------------------------------------------------
	// control and storage state
	// ---------------------------------------------------------------
	npsc_pkg::state_t                 state_q, state_d;
	logic [npsc_pkg::DIMS_W-1:0]      dims_q;
	logic [npsc_pkg::CNT_W-1:0]       count_q;
	logic [npsc_pkg::IDX_W-1:0]       rd_addr_q;
	logic [npsc_pkg::IDX_W-1:0]       last_addr;
	logic                             in_fire;
	logic                             is_append;
	logic                             is_query;
	logic                             is_clear;
	logic                             store_full;
	logic                             ram_we;
	logic                             rd_en;
	logic                             emit_go;
	logic                             scan_end;
	npsc_pkg::point_t                 wr_point;
	npsc_pkg::point_t                 rd_point;

	// chain words: slot 0 is the memory output stage, last slot is the tail
	npsc_pkg::word_t                  chain [npsc_pkg::NUM_AXES+1];
	logic [npsc_pkg::NUM_AXES-1:0]    use_axis;
	npsc_pkg::point_t                 q_point;

	logic                             vld_s1;
	logic                             last_s1;
	logic [npsc_pkg::IDX_W-1:0]       idx_s1;

	// running minimum
	logic                             have_q;
	logic [npsc_pkg::DSUM_W-1:0]      best_q;
	logic [npsc_pkg::IDX_W-1:0]       best_idx_q;
	logic                             take_tail;
	npsc_pkg::word_t                  tail;

	// output register
	logic                             out_valid_q;
	logic                             found_q;
	logic [npsc_pkg::OUT_IDX_W-1:0]   best_index_q;
	logic [npsc_pkg::OUT_DIST_W-1:0]  best_dist_q;

	// ---------------------------------------------------------------
	// input decode
	// ---------------------------------------------------------------
	assign in_fire    = in_valid && in_ready;
	assign is_clear   = in_fire && (opcode == npsc_pkg::OP_CLEAR);
	assign is_append  = in_fire && (opcode == npsc_pkg::OP_APPEND);
	assign is_query   = in_fire && (opcode == npsc_pkg::OP_QUERY);
	assign store_full = (count_q == npsc_pkg::CNT_W'(npsc_pkg::MAX_POINTS));
	assign ram_we     = is_append && !store_full;

	assign wr_point[0] = npsc_pkg::to_coord(coord_x);
	assign wr_point[1] = npsc_pkg::to_coord(coord_y);
	assign wr_point[2] = npsc_pkg::to_coord(coord_z);
	assign q_point     = wr_point;

	// last stored point address, only looked at while count is nonzero
	assign last_addr = npsc_pkg::IDX_W'(count_q - npsc_pkg::CNT_W'(1));
	assign scan_end  = (rd_addr_q == last_addr);
	assign tail      = chain[npsc_pkg::NUM_AXES];

	// ---------------------------------------------------------------
	// state machine
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			npsc_pkg::ST_IDLE: begin
				if (is_query) begin
					state_d = (count_q == '0) ? npsc_pkg::ST_EMIT : npsc_pkg::ST_SCAN;
				end
			end
			npsc_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = npsc_pkg::ST_WAIT;
				end
			end
			npsc_pkg::ST_WAIT: begin
				if (tail.vld && tail.last) begin
					state_d = npsc_pkg::ST_EMIT;
				end
			end
			npsc_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = npsc_pkg::ST_IDLE;
				end
			end
			default: state_d = npsc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		emit_go  = 1'b0;
		unique case (state_q)
			npsc_pkg::ST_IDLE: in_ready = 1'b1;
			npsc_pkg::ST_SCAN: rd_en    = 1'b1;
			npsc_pkg::ST_WAIT: ;
			npsc_pkg::ST_EMIT: emit_go  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------
	// dimensions register, point count and scan address
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q    <= npsc_pkg::DIMS_THREE;
			count_q   <= '0;
			rd_addr_q <= '0;
		end else begin
			if (cfg_write_en) begin
				dims_q <= cfg_write_data;
			end
			if (is_clear) begin
				count_q <= '0;
			end else if (ram_we) begin
				count_q <= count_q + npsc_pkg::CNT_W'(1);
			end
			// scan always starts from the first loaded point
			if (is_query) begin
				rd_addr_q <= '0;
			end else if (rd_en) begin
				rd_addr_q <= rd_addr_q + npsc_pkg::IDX_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// point memory, one point per entry, x in the low slice
	// ---------------------------------------------------------------
	npsc_ram #(
		.WIDTH(npsc_pkg::NUM_AXES * npsc_pkg::COORD_W),
		.DEPTH(npsc_pkg::MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[npsc_pkg::IDX_W-1:0]),
		.wdata (wr_point),
		.re    (rd_en),
		.raddr (rd_addr_q),
		.rdata (rd_point)
	);

	// stage 1 tags travel alongside the registered memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= scan_end;
		idx_s1  <= rd_addr_q;
	end

	always_comb begin
		chain[0].vld  = vld_s1;
		chain[0].last = last_s1;
		chain[0].idx  = idx_s1;
		chain[0].sum  = '0;
		chain[0].pt   = rd_point;
	end

	// ---------------------------------------------------------------
	// axis cell chain: x, y, then z (z adds nothing in two-axis mode)
	// ---------------------------------------------------------------
	assign use_axis = {dims_q == npsc_pkg::DIMS_THREE, 2'b11};

	for (genvar k = 0; k < npsc_pkg::NUM_AXES; k++) begin : g_cell
		npsc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.q_load   (is_query),
			.q_coord  (q_point[k]),
			.use_axis (use_axis[k]),
			.word_in  (chain[k]),
			.word_out (chain[k+1])
		);
	end

	// ---------------------------------------------------------------
	// running minimum; strict less-than keeps the first on ties
	// ---------------------------------------------------------------
	assign take_tail = tail.vld && (!have_q || (tail.sum < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (is_query) begin
			have_q     <= 1'b0;
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (take_tail) begin
			have_q     <= 1'b1;
			best_q     <= tail.sum;
			best_idx_q <= tail.idx;
		end
	end

	// ---------------------------------------------------------------
	// output register with saturation of the reported distance
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			found_q      <= have_q;
			best_index_q <= npsc_pkg::OUT_IDX_W'(best_idx_q);
			if (best_q > npsc_pkg::DSUM_W'({npsc_pkg::OUT_DIST_W{1'b1}})) begin
				best_dist_q <= '1;
			end else begin
				best_dist_q <= npsc_pkg::OUT_DIST_W'(best_q);
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign found            = found_q;
	assign best_index       = best_index_q;
	assign best_distance_sq = best_dist_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= npsc_pkg::CNT_W'(npsc_pkg::MAX_POINTS))
		else $error("point count above store depth");

	a_idle_empty_chain: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!vld_s1 && !tail.vld))
		else $error("chain holds a word while taking commands");

	a_tail_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.vld && tail.last) |-> (state_q == npsc_pkg::ST_WAIT))
		else $error("last distance arrived outside wait state");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (best_index == '0 && best_distance_sq == '0))
		else $error("empty store result carries nonzero fields");

endmodule
